[hw/rtl/pn2d_pkg.sv]
// ----------------------------------------------------------------------------
// pn2d_pkg: shared definitions for the 2D gradient-noise block
// Fixed-point formats, queue sizes, the permutation table and the gradient
// dot product used by the front and back parts.
// ----------------------------------------------------------------------------
package pn2d_pkg;

    localparam int FRAC_BITS = 16;
    localparam int COORD_W   = 32;
    localparam int CELL_W    = 8;
    localparam int HASH_W    = 2;
    localparam int OUT_W     = 18;
    localparam int OUT_FRAC  = 16;

    // Offset (unsigned fraction), dot/lerp value, fade seed and fade polynomial
    localparam int F_W = FRAC_BITS;
    localparam int D_W = FRAC_BITS + 3;
    localparam int S_W = FRAC_BITS + 5;
    localparam int P_W = FRAC_BITS + 4;

    localparam longint ONE     = 64'sd1 << FRAC_BITS;
    localparam longint OUT_MAX = 64'sd1 << OUT_FRAC;

    localparam int OUT_SHL = (FRAC_BITS < OUT_FRAC) ? OUT_FRAC - FRAC_BITS : 0;
    localparam int OUT_SHR = (FRAC_BITS > OUT_FRAC) ? FRAC_BITS - OUT_FRAC : 0;
    localparam int SC_W    = D_W + OUT_SHL;

    localparam int MQ_DEPTH = 4;
    localparam int MQ_PTR_W = 2;
    localparam int MQ_CNT_W = 3;
    localparam int OQ_DEPTH = 16;
    localparam int OQ_PTR_W = 4;
    localparam int OQ_CNT_W = 5;
    localparam int BK_STAGES = 7;

    // Gradient codes from the low two hash bits
    localparam logic [HASH_W-1:0] GRAD_PP = 2'd0;
    localparam logic [HASH_W-1:0] GRAD_MP = 2'd1;
    localparam logic [HASH_W-1:0] GRAD_PM = 2'd2;
    localparam logic [HASH_W-1:0] GRAD_MM = 2'd3;

    typedef struct packed {
        logic [F_W-1:0]    fx;
        logic [F_W-1:0]    fy;
        logic [HASH_W-1:0] h00;
        logic [HASH_W-1:0] h10;
        logic [HASH_W-1:0] h01;
        logic [HASH_W-1:0] h11;
    } t_cell_item;

    typedef struct packed {
        logic                empty;
        logic [MQ_CNT_W-1:0] count;
    } t_mq_status;

    localparam logic [7:0] PERM [256] = '{
        8'd151, 8'd160, 8'd137, 8'd91,  8'd90,  8'd15,  8'd131, 8'd13,
        8'd201, 8'd95,  8'd96,  8'd53,  8'd194, 8'd233, 8'd7,   8'd225,
        8'd140, 8'd36,  8'd103, 8'd30,  8'd69,  8'd142, 8'd8,   8'd99,
        8'd37,  8'd240, 8'd21,  8'd10,  8'd23,  8'd190, 8'd6,   8'd148,
        8'd247, 8'd120, 8'd234, 8'd75,  8'd0,   8'd26,  8'd197, 8'd62,
        8'd94,  8'd252, 8'd219, 8'd203, 8'd117, 8'd35,  8'd11,  8'd32,
        8'd57,  8'd177, 8'd33,  8'd88,  8'd237, 8'd149, 8'd56,  8'd87,
        8'd174, 8'd20,  8'd125, 8'd136, 8'd171, 8'd168, 8'd68,  8'd175,
        8'd74,  8'd165, 8'd71,  8'd134, 8'd139, 8'd48,  8'd27,  8'd166,
        8'd77,  8'd146, 8'd158, 8'd231, 8'd83,  8'd111, 8'd229, 8'd122,
        8'd60,  8'd211, 8'd133, 8'd230, 8'd220, 8'd105, 8'd92,  8'd41,
        8'd55,  8'd46,  8'd245, 8'd40,  8'd244, 8'd102, 8'd143, 8'd54,
        8'd65,  8'd25,  8'd63,  8'd161, 8'd1,   8'd216, 8'd80,  8'd73,
        8'd209, 8'd76,  8'd132, 8'd187, 8'd208, 8'd89,  8'd18,  8'd169,
        8'd200, 8'd196, 8'd135, 8'd130, 8'd116, 8'd188, 8'd159, 8'd86,
        8'd164, 8'd100, 8'd109, 8'd198, 8'd173, 8'd186, 8'd3,   8'd64,
        8'd52,  8'd217, 8'd226, 8'd250, 8'd124, 8'd123, 8'd5,   8'd202,
        8'd38,  8'd147, 8'd118, 8'd126, 8'd255, 8'd82,  8'd85,  8'd212,
        8'd207, 8'd206, 8'd59,  8'd227, 8'd47,  8'd16,  8'd58,  8'd17,
        8'd182, 8'd189, 8'd28,  8'd42,  8'd223, 8'd183, 8'd170, 8'd213,
        8'd119, 8'd248, 8'd152, 8'd2,   8'd44,  8'd154, 8'd163, 8'd70,
        8'd221, 8'd153, 8'd101, 8'd155, 8'd167, 8'd43,  8'd172, 8'd9,
        8'd129, 8'd22,  8'd39,  8'd253, 8'd19,  8'd98,  8'd108, 8'd110,
        8'd79,  8'd113, 8'd224, 8'd232, 8'd178, 8'd185, 8'd112, 8'd104,
        8'd218, 8'd246, 8'd97,  8'd228, 8'd251, 8'd34,  8'd242, 8'd193,
        8'd238, 8'd210, 8'd144, 8'd12,  8'd191, 8'd179, 8'd162, 8'd241,
        8'd81,  8'd51,  8'd145, 8'd235, 8'd249, 8'd14,  8'd239, 8'd107,
        8'd49,  8'd192, 8'd214, 8'd31,  8'd181, 8'd199, 8'd106, 8'd157,
        8'd184, 8'd84,  8'd204, 8'd176, 8'd115, 8'd121, 8'd50,  8'd45,
        8'd127, 8'd4,   8'd150, 8'd254, 8'd138, 8'd236, 8'd205, 8'd93,
        8'd222, 8'd114, 8'd67,  8'd29,  8'd24,  8'd72,  8'd243, 8'd141,
        8'd128, 8'd195, 8'd78,  8'd66,  8'd215, 8'd61,  8'd156, 8'd180
    };

    function automatic logic [7:0] perm_at(input logic [CELL_W-1:0] idx);
        return PERM[idx];
    endfunction

    function automatic logic signed [D_W-1:0] grad_dot(
        input logic [HASH_W-1:0]     h,
        input logic signed [D_W-1:0] dx,
        input logic signed [D_W-1:0] dy
    );
        logic signed [D_W-1:0] res;
        unique case (h)
            GRAD_PP: res = dx + dy;
            GRAD_MP: res = dy - dx;
            GRAD_PM: res = dx - dy;
            GRAD_MM: res = -dx - dy;
            default: res = '0;
        endcase
        return res;
    endfunction

endpackage

[hw/rtl/perlin_noise_2d_top.sv]
// ----------------------------------------------------------------------------
// perlin_noise_2d_top: 2D gradient noise, one point per cycle while results are popped
// Each point in Q15.16 gives one noise value in Q1.16.
// ----------------------------------------------------------------------------
// Usage:
//   Points enter through a queue-style port: a word is taken at a clock edge
//   with push high and full low. Results leave the same way: while empty is
//   low the oldest result is on o_noise_value, and pop takes it.
//   A point passes the hashing register, the cell queue, the back pipeline
//   and the result queue before empty goes low. One point is taken every cycle
//   for as long as results are popped at the same rate.
//   The front hashes the cell corners through the permutation table and
//   fills a four-deep cell queue; the back runs the fade polynomial and the
//   interpolation in a seven-stage pipeline that draws a cell only when its
//   sixteen-deep result queue has room for every word in flight.
//   When the receiver stops popping, the result queue fills, the back stops
//   drawing cells, the cell queue fills and full rises; nothing is lost.
//   Reset empties both queues and the pipelines; no clearing pass is needed.
// ----------------------------------------------------------------------------
module perlin_noise_2d_top
    import pn2d_pkg::*;
(
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      push,
    output logic                      full,
    input  logic signed [COORD_W-1:0] i_x_coord,
    input  logic signed [COORD_W-1:0] i_y_coord,
    output logic                      empty,
    input  logic                      pop,
    output logic signed [OUT_W-1:0]   o_noise_value
);

    t_mq_status mq_status;
    t_cell_item mq_wr_item;
    t_cell_item mq_rd_item;
    logic       mq_wr;
    logic       mq_rd;

    pn2_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .push        (push),
        .i_x_coord   (i_x_coord),
        .i_y_coord   (i_y_coord),
        .i_mq_status (mq_status),
        .full        (full),
        .o_mq_wr     (mq_wr),
        .o_mq_item   (mq_wr_item)
    );

    pn2_queue u_queue (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr      (mq_wr),
        .i_wr_item (mq_wr_item),
        .i_rd      (mq_rd),
        .o_rd_item (mq_rd_item),
        .o_status  (mq_status)
    );

    pn2_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_mq_item     (mq_rd_item),
        .i_mq_status   (mq_status),
        .o_mq_rd       (mq_rd),
        .pop           (pop),
        .empty         (empty),
        .o_noise_value (o_noise_value)
    );

endmodule

[hw/rtl/pn2_front.sv]
// ----------------------------------------------------------------------------
// pn2_front: point intake and corner hashing
// Splits each point into cell and offset, looks up the four corner hashes
// in two table steps and writes the result into the cell queue.
// ----------------------------------------------------------------------------
module pn2_front
    import pn2d_pkg::*;
(
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       push,
    input  logic signed [COORD_W-1:0]  i_x_coord,
    input  logic signed [COORD_W-1:0]  i_y_coord,
    input  t_mq_status                 i_mq_status,
    output logic                       full,
    output logic                       o_mq_wr,
    output t_cell_item                 o_mq_item
);

    logic              r_v1;
    logic [7:0]        r_px0;
    logic [7:0]        r_px1;
    logic [CELL_W-1:0] r_cy;
    logic [F_W-1:0]    r_fx;
    logic [F_W-1:0]    r_fy;

    logic              accept;
    logic [CELL_W-1:0] cx;
    logic [CELL_W-1:0] cy1;
    logic [7:0]        hv00;
    logic [7:0]        hv10;
    logic [7:0]        hv01;
    logic [7:0]        hv11;

    // A word in the hashing stage is counted against the free queue slots.
    assign full   = (i_mq_status.count + MQ_CNT_W'(r_v1)) >= MQ_CNT_W'(MQ_DEPTH);
    assign accept = push & ~full;
    assign cx     = i_x_coord[FRAC_BITS +: CELL_W];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else begin
            r_v1 <= accept;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_px0 <= perm_at(cx);
            r_px1 <= perm_at(CELL_W'(cx + CELL_W'(1)));
            r_cy  <= i_y_coord[FRAC_BITS +: CELL_W];
            r_fx  <= i_x_coord[F_W-1:0];
            r_fy  <= i_y_coord[F_W-1:0];
        end
    end

    assign cy1  = CELL_W'(r_cy + CELL_W'(1));
    assign hv00 = perm_at(CELL_W'(r_px0 + r_cy));
    assign hv10 = perm_at(CELL_W'(r_px1 + r_cy));
    assign hv01 = perm_at(CELL_W'(r_px0 + cy1));
    assign hv11 = perm_at(CELL_W'(r_px1 + cy1));

    assign o_mq_wr       = r_v1;
    assign o_mq_item.fx  = r_fx;
    assign o_mq_item.fy  = r_fy;
    assign o_mq_item.h00 = hv00[HASH_W-1:0];
    assign o_mq_item.h10 = hv10[HASH_W-1:0];
    assign o_mq_item.h01 = hv01[HASH_W-1:0];
    assign o_mq_item.h11 = hv11[HASH_W-1:0];

endmodule

[hw/rtl/pn2_queue.sv]
// ----------------------------------------------------------------------------
// pn2_queue: cell queue between front and back
// A short first-in first-out store of hashed cells so that either side can
// stall without holding the other.
// ----------------------------------------------------------------------------
module pn2_queue
    import pn2d_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_wr,
    input  t_cell_item  i_wr_item,
    input  logic        i_rd,
    output t_cell_item  o_rd_item,
    output t_mq_status  o_status
);

    t_cell_item          r_mem [MQ_DEPTH];
    logic [MQ_PTR_W-1:0] r_head;
    logic [MQ_PTR_W-1:0] r_tail;
    logic [MQ_CNT_W-1:0] r_count;
    logic [MQ_CNT_W-1:0] n_count;

    always_comb begin
        n_count = r_count;
        if (i_wr && !i_rd) begin
            n_count = r_count + MQ_CNT_W'(1);
        end else if (!i_wr && i_rd) begin
            n_count = r_count - MQ_CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_tail  <= '0;
            r_count <= '0;
        end else begin
            if (i_wr) begin
                r_tail <= r_tail + MQ_PTR_W'(1);
            end
            if (i_rd) begin
                r_head <= r_head + MQ_PTR_W'(1);
            end
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr) begin
            r_mem[r_tail] <= i_wr_item;
        end
    end

    assign o_rd_item      = r_mem[r_head];
    assign o_status.empty = (r_count == '0);
    assign o_status.count = r_count;

endmodule

[hw/rtl/pn2_back.sv]
// ----------------------------------------------------------------------------
// pn2_back: fade, dot products and interpolation
// A seven-stage pipeline that never stalls: a cell is taken from the queue
// only when the result queue has room for every word in flight.
// ----------------------------------------------------------------------------
module pn2_back
    import pn2d_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  t_cell_item               i_mq_item,
    input  t_mq_status               i_mq_status,
    output logic                     o_mq_rd,
    input  logic                     pop,
    output logic                     empty,
    output logic signed [OUT_W-1:0]  o_noise_value
);

    typedef struct packed {
        logic signed [D_W-1:0] d00;
        logic signed [D_W-1:0] d10;
        logic signed [D_W-1:0] d01;
        logic signed [D_W-1:0] d11;
    } t_dots;

    logic [BK_STAGES-1:0] r_v;

    // Stage 0: fade seed 6f - 15 and the four dot products
    logic signed [S_W-1:0] r0_sx, r0_sy;
    logic [F_W-1:0]        r0_fx, r0_fy;
    t_dots                 r0_d;
    // Stages 1 to 3: fade polynomial, then the polynomial times f twice
    logic [P_W-1:0]        r1_px, r1_py;
    logic [F_W-1:0]        r1_fx, r1_fy;
    t_dots                 r1_d;
    logic [P_W-1:0]        r2_qx, r2_qy;
    logic [F_W-1:0]        r2_fx, r2_fy;
    t_dots                 r2_d;
    logic [P_W-1:0]        r3_qx, r3_qy;
    logic [F_W-1:0]        r3_fx, r3_fy;
    t_dots                 r3_d;
    // Stage 4: fade weights; stage 5: lerp along x; stage 6: lerp along y
    logic [F_W-1:0]        r4_u, r4_v;
    t_dots                 r4_d;
    logic signed [D_W-1:0] r5_l0, r5_l1;
    logic [F_W-1:0]        r5_v;
    logic signed [D_W-1:0] r6_r;

    logic signed [D_W-1:0]     fxs, fxm, fys, fym;
    t_dots                     n0_d;
    logic signed [S_W+F_W:0]   m1x, m1y;
    logic [P_W+F_W-1:0]        m2x, m2y, m3x, m3y, m4x, m4y;
    logic signed [D_W:0]       dfa, dfb, dfc;
    logic signed [F_W+D_W+1:0] mla, mlb, mlc;
    logic signed [SC_W-1:0]    sc;
    logic signed [OUT_W-1:0]   sat;

    logic signed [OUT_W-1:0] r_oq [OQ_DEPTH];
    logic [OQ_PTR_W-1:0]     r_oq_head;
    logic [OQ_PTR_W-1:0]     r_oq_tail;
    logic [OQ_CNT_W-1:0]     r_oq_count;
    logic                    oq_wr;
    logic                    oq_rd;

    // Credit check: queued results plus words in the pipeline stay within
    // the result queue, so the pipeline itself never has to hold.
    assign o_mq_rd = ~i_mq_status.empty &&
                     ((r_oq_count + OQ_CNT_W'($countones(r_v))) < OQ_CNT_W'(OQ_DEPTH));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            r_v <= {r_v[BK_STAGES-2:0], o_mq_rd};
        end
    end

    // Offsets relative to the near and far corners
    assign fxs = D_W'(i_mq_item.fx);
    assign fys = D_W'(i_mq_item.fy);
    assign fxm = fxs - D_W'(ONE);
    assign fym = fys - D_W'(ONE);

    assign n0_d.d00 = grad_dot(i_mq_item.h00, fxs, fys);
    assign n0_d.d10 = grad_dot(i_mq_item.h10, fxm, fys);
    assign n0_d.d01 = grad_dot(i_mq_item.h01, fxs, fym);
    assign n0_d.d11 = grad_dot(i_mq_item.h11, fxm, fym);

    assign m1x = r0_sx * $signed({1'b0, r0_fx});
    assign m1y = r0_sy * $signed({1'b0, r0_fy});
    assign m2x = r1_px * r1_fx;
    assign m2y = r1_py * r1_fy;
    assign m3x = r2_qx * r2_fx;
    assign m3y = r2_qy * r2_fy;
    assign m4x = r3_qx * r3_fx;
    assign m4y = r3_qy * r3_fy;

    assign dfa = (D_W+1)'(r4_d.d10) - (D_W+1)'(r4_d.d00);
    assign dfb = (D_W+1)'(r4_d.d11) - (D_W+1)'(r4_d.d01);
    assign mla = $signed({1'b0, r4_u}) * dfa;
    assign mlb = $signed({1'b0, r4_u}) * dfb;
    assign dfc = (D_W+1)'(r5_l1) - (D_W+1)'(r5_l0);
    assign mlc = $signed({1'b0, r5_v}) * dfc;

    always_ff @(posedge i_clk) begin
        r0_sx <= S_W'(i_mq_item.fx) * S_W'(6) - S_W'(15 * ONE);
        r0_sy <= S_W'(i_mq_item.fy) * S_W'(6) - S_W'(15 * ONE);
        r0_fx <= i_mq_item.fx;
        r0_fy <= i_mq_item.fy;
        r0_d  <= n0_d;

        r1_px <= P_W'(m1x >>> FRAC_BITS) + P_W'(10 * ONE);
        r1_py <= P_W'(m1y >>> FRAC_BITS) + P_W'(10 * ONE);
        r1_fx <= r0_fx;
        r1_fy <= r0_fy;
        r1_d  <= r0_d;

        r2_qx <= m2x[F_W +: P_W];
        r2_qy <= m2y[F_W +: P_W];
        r2_fx <= r1_fx;
        r2_fy <= r1_fy;
        r2_d  <= r1_d;

        r3_qx <= m3x[F_W +: P_W];
        r3_qy <= m3y[F_W +: P_W];
        r3_fx <= r2_fx;
        r3_fy <= r2_fy;
        r3_d  <= r2_d;

        r4_u  <= m4x[F_W +: F_W];
        r4_v  <= m4y[F_W +: F_W];
        r4_d  <= r3_d;

        r5_l0 <= r4_d.d00 + D_W'(mla >>> FRAC_BITS);
        r5_l1 <= r4_d.d01 + D_W'(mlb >>> FRAC_BITS);
        r5_v  <= r4_v;

        r6_r  <= r5_l0 + D_W'(mlc >>> FRAC_BITS);
    end

    // Rescale to 16 fraction bits, then clamp to plus or minus one.
    always_comb begin
        sc = (SC_W'(r6_r) <<< OUT_SHL) >>> OUT_SHR;
        if (sc > SC_W'(OUT_MAX)) begin
            sat = OUT_W'(OUT_MAX);
        end else if (sc < -SC_W'(OUT_MAX)) begin
            sat = -OUT_W'(OUT_MAX);
        end else begin
            sat = OUT_W'(sc);
        end
    end

    assign oq_wr = r_v[BK_STAGES-1];
    assign oq_rd = pop & ~empty;
    assign empty = (r_oq_count == '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_oq_head  <= '0;
            r_oq_tail  <= '0;
            r_oq_count <= '0;
        end else begin
            if (oq_wr) begin
                r_oq_tail <= r_oq_tail + OQ_PTR_W'(1);
            end
            if (oq_rd) begin
                r_oq_head <= r_oq_head + OQ_PTR_W'(1);
            end
            if (oq_wr && !oq_rd) begin
                r_oq_count <= r_oq_count + OQ_CNT_W'(1);
            end else if (!oq_wr && oq_rd) begin
                r_oq_count <= r_oq_count - OQ_CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (oq_wr) begin
            r_oq[r_oq_tail] <= sat;
        end
    end

    assign o_noise_value = r_oq[r_oq_head];

endmodule

[bench/perlin_noise_2d_checker.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// perlin_noise_2d_checker: result predictor and scoreboard for the noise block
// Watches both queue ports of the block. Every point that is pushed is turned
// into an expected noise value by an independent fixed-point model. Every word
// that is popped is compared against the oldest expected value.
// ----------------------------------------------------------------------------
module perlin_noise_2d_checker
    import pn2d_pkg::*;
(
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_push,
    input  logic                      i_full,
    input  logic signed [COORD_W-1:0] i_x_coord,
    input  logic signed [COORD_W-1:0] i_y_coord,
    input  logic                      i_empty,
    input  logic                      i_pop,
    input  logic signed [OUT_W-1:0]   i_noise_value,
    output int                        o_error_count,
    output int                        o_pending,
    output int                        o_checked
);

    logic signed [OUT_W-1:0] noise_expected [$];
    logic signed [OUT_W-1:0] want;
    int                      error_count;
    int                      checked;

    // Quintic fade 6t^5 - 15t^4 + 10t^3, each product floored to the fraction.
    function automatic longint fade_curve(input longint f);
        longint poly;
        longint q;
        poly = (((6 * f - 15 * ONE) * f) >>> FRAC_BITS) + 10 * ONE;
        q = (poly * f) >>> FRAC_BITS;
        q = (q * f) >>> FRAC_BITS;
        return (q * f) >>> FRAC_BITS;
    endfunction

    function automatic longint blend(input longint w, input longint a, input longint b);
        return a + ((w * (b - a)) >>> FRAC_BITS);
    endfunction

    function automatic longint corner_dot(input logic [7:0] h, input longint dx,
                                          input longint dy);
        longint res;
        case (h[HASH_W-1:0])
            GRAD_PP: res = dx + dy;
            GRAD_MP: res = dy - dx;
            GRAD_PM: res = dx - dy;
            GRAD_MM: res = -dx - dy;
            default: res = 0;
        endcase
        return res;
    endfunction

    function automatic logic signed [OUT_W-1:0] noise_at(
        input logic signed [COORD_W-1:0] x,
        input logic signed [COORD_W-1:0] y
    );
        logic [7:0] cx, cy, px0, px1;
        logic [7:0] h00, h10, h01, h11;
        longint     fx, fy, u, v, r;
        cx  = x[FRAC_BITS+7 -: 8];
        cy  = y[FRAC_BITS+7 -: 8];
        fx  = x[FRAC_BITS-1:0];
        fy  = y[FRAC_BITS-1:0];
        u   = fade_curve(fx);
        v   = fade_curve(fy);
        // All lattice index sums wrap at 256, as with a doubled table.
        px0 = PERM[cx];
        px1 = PERM[8'(cx + 8'd1)];
        h00 = PERM[8'(px0 + cy)];
        h10 = PERM[8'(px1 + cy)];
        h01 = PERM[8'(px0 + cy + 8'd1)];
        h11 = PERM[8'(px1 + cy + 8'd1)];
        r = blend(v,
                  blend(u, corner_dot(h00, fx, fy), corner_dot(h10, fx - ONE, fy)),
                  blend(u, corner_dot(h01, fx, fy - ONE),
                        corner_dot(h11, fx - ONE, fy - ONE)));
        r = (r <<< OUT_SHL) >>> OUT_SHR;
        if (r > OUT_MAX) r = OUT_MAX;
        if (r < -OUT_MAX) r = -OUT_MAX;
        return OUT_W'(r);
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            noise_expected.delete();
            error_count = 0;
            checked = 0;
        end else begin
            // Pops are checked first so a word cannot match a point pushed
            // on the same edge.
            if (i_pop && !i_empty) begin
                if (noise_expected.size() == 0) begin
                    $error("noise_value: expected no word, got %0d", i_noise_value);
                    error_count++;
                end else begin
                    want = noise_expected.pop_front();
                    checked++;
                    if (i_noise_value !== want) begin
                        $error("noise_value: expected %0d, got %0d", want, i_noise_value);
                        error_count++;
                    end
                end
            end
            if (i_push && !i_full) begin
                noise_expected.push_back(noise_at(i_x_coord, i_y_coord));
            end
        end
        o_error_count <= error_count;
        o_pending     <= noise_expected.size();
        o_checked     <= checked;
    end

endmodule

[bench/perlin_noise_2d_top_test.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// perlin_noise_2d_top_test: stimulus and verdict for the noise block
// Pushes directed corner points and about a thousand random points in bursts
// while the receiver pops on a random pattern, with one long receiver stall
// and one full drain. The checker beside the block does the comparison.
// ----------------------------------------------------------------------------
module perlin_noise_2d_top_test;
    import pn2d_pkg::*;

    localparam int RANDOM_POINTS = 1030;
    localparam int LATENCY       = 10;
    localparam int IDLE_LIMIT    = 2000;
    localparam int LONG_HOLD     = 300;
    localparam int HOLD_AT       = 250;
    localparam int PAUSE_AT      = 600;

    typedef enum int {
        POP_ALWAYS,
        POP_HALF,
        POP_RARE,
        POP_OFTEN
    } t_pop_mode;

    localparam logic [15:0] EDGE_FRAC [4] = '{16'h0000, 16'h0001, 16'h8000, 16'hFFFF};

    logic                      i_clk     = 1'b0;
    logic                      i_rst_n   = 1'b0;
    logic                      push      = 1'b0;
    logic                      pop       = 1'b0;
    logic signed [COORD_W-1:0] x_coord   = '0;
    logic signed [COORD_W-1:0] y_coord   = '0;
    logic                      full;
    logic                      empty;
    logic signed [OUT_W-1:0]   noise_value;

    int error_count;
    int pending;
    int checked;
    int points_sent  = 0;
    int full_stalls  = 0;
    int burst_left   = 0;
    bit hold_request = 1'b0;
    bit hold_done    = 1'b0;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    perlin_noise_2d_top u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .push          (push),
        .full          (full),
        .i_x_coord     (x_coord),
        .i_y_coord     (y_coord),
        .empty         (empty),
        .pop           (pop),
        .o_noise_value (noise_value)
    );

    perlin_noise_2d_checker u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_push        (push),
        .i_full        (full),
        .i_x_coord     (x_coord),
        .i_y_coord     (y_coord),
        .i_empty       (empty),
        .i_pop         (pop),
        .i_noise_value (noise_value),
        .o_error_count (error_count),
        .o_pending     (pending),
        .o_checked     (checked)
    );

    // Offers one point, opening a new burst after a random gap when the
    // current one is used up, and waits until the word is taken.
    task automatic send_point(input logic signed [COORD_W-1:0] x,
                              input logic signed [COORD_W-1:0] y);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 48);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0) begin
                push <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        push    <= 1'b1;
        x_coord <= x;
        y_coord <= y;
        @(posedge i_clk);
        while (full) begin
            full_stalls++;
            @(posedge i_clk);
        end
        points_sent++;
        if (points_sent == HOLD_AT) hold_request = 1'b1;
    endtask

    initial begin : stimulus
        logic signed [COORD_W-1:0] x, y;
        int                        pick;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_point(32'sh0000_0000, 32'sh0000_0000);
        send_point(32'sh7FFF_FFFF, 32'sh7FFF_FFFF);
        send_point(32'sh8000_0000, 32'sh8000_0000);
        send_point(32'sh7FFF_FFFF, 32'sh8000_0000);
        send_point(32'sh8000_0000, 32'sh7FFF_FFFF);
        // Just below zero: cell 255 with an offset close to one.
        send_point(-32'sd1, -32'sd1);
        send_point(-32'sh0000_8000, 32'sh0000_8000);
        send_point(32'sh00FF_FFFF, 32'sh00FF_FFFF);
        send_point(32'sh00FF_8000, 32'sh0000_0001);
        send_point(32'sh0001_0000, 32'sh00FF_0000);
        send_point(32'sh0000_FFFF, 32'sh0000_0000);
        send_point(32'sh0000_0001, 32'sh0000_FFFF);
        send_point(32'sh1234_5678, -32'sh1234_5678);
        send_point(32'shFF00_0000, 32'sh00FF_0000);
        // Cell centers, where all four dot products can add up to full scale.
        for (int k = 0; k < 8; k++) begin
            send_point({8'h00, 8'(k * 37), 16'h8000}, {8'h00, 8'(k * 91 + 5), 16'h8000});
        end

        for (int i = 0; i < RANDOM_POINTS; i++) begin
            if (points_sent == PAUSE_AT) begin
                push <= 1'b0;
                @(posedge i_clk);
                while (pending != 0) @(posedge i_clk);
            end
            x = $urandom();
            y = $urandom();
            pick = $urandom_range(0, 9);
            if (pick == 0) x[15:0] = EDGE_FRAC[$urandom_range(0, 3)];
            if (pick == 1) y[15:0] = EDGE_FRAC[$urandom_range(0, 3)];
            send_point(x, y);
        end

        push <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (2 * LATENCY) @(posedge i_clk);

        $display("Pushed %0d points (%0d directed) and checked %0d noise words.",
                 points_sent, points_sent - RANDOM_POINTS, checked);
        $display("Input was held off by a full queue on %0d cycles.", full_stalls);
        if (error_count == 0 && pending == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

    // The receiver pops in segments of random character; once, after the
    // sender has reached a set count, it stops popping for a long stretch.
    initial begin : receiver
        int        seg_len;
        t_pop_mode mode;
        forever begin
            if (hold_request && !hold_done) begin
                hold_done = 1'b1;
                pop <= 1'b0;
                repeat (LONG_HOLD) @(posedge i_clk);
            end
            seg_len = $urandom_range(1, 64);
            mode = t_pop_mode'($urandom_range(0, 3));
            repeat (seg_len) begin
                case (mode)
                    POP_ALWAYS: pop <= 1'b1;
                    POP_HALF:   pop <= 1'($urandom_range(0, 1));
                    POP_RARE:   pop <= ($urandom_range(0, 3) == 0);
                    default:    pop <= ($urandom_range(0, 3) != 0);
                endcase
                @(posedge i_clk);
            end
        end
    end

    initial begin : watchdog
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < IDLE_LIMIT) begin
            @(posedge i_clk);
            if ((push && !full) || (pop && !empty)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
        end
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

[filelist.f]
hw/rtl/pn2d_pkg.sv
hw/rtl/pn2_front.sv
hw/rtl/pn2_queue.sv
hw/rtl/pn2_back.sv
hw/rtl/perlin_noise_2d_top.sv
bench/perlin_noise_2d_checker.sv
bench/perlin_noise_2d_top_test.sv
